// ----- sv/i2cm_pkg.sv -----
// Shared codes, types and constants of the I2C master byte engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cm_pkg;

	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_START     = 3'd1;
	localparam logic [2:0] MODE_STOP      = 3'd2;
	localparam logic [2:0] MODE_WRITE     = 3'd3;
	localparam logic [2:0] MODE_READ_ACK  = 3'd4;
	localparam logic [2:0] MODE_READ_NACK = 3'd5;

	localparam logic [15:0] PHASE_DELAY_RESET = 16'd13;
	localparam int unsigned BYTE_MSB          = 7;

	// Line pattern driven on the bus.
	typedef struct packed {
		logic drv;
		logic sda;
		logic scl;
	} line_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] tx_byte;
		logic       sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       slave_ack;
		logic       cmd_rejected;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/i2cm_if.sv -----
// Valid/ready channel interfaces for the tick items and the per-tick results.
`timescale 1ns / 1ps
`default_nettype none
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] tx_byte;
	logic       sda_sample;

	modport source (output valid, output mode, output tx_byte, output sda_sample,
		input ready);
	modport sink (input valid, input mode, input tx_byte, input sda_sample,
		output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       slave_ack;
	logic       cmd_rejected;

	modport source (output valid, output scl_level, output sda_level, output sda_drive,
		output busy_res, output done_res, output rx_byte, output slave_ack,
		output cmd_rejected, input ready);
	modport sink (input valid, input scl_level, input sda_level, input sda_drive,
		input busy_res, input done_res, input rx_byte, input slave_ack,
		input cmd_rejected, output ready);
endinterface
`default_nettype wire

// ----- sv/i2cm_step.sv -----
// Bit engine state and the single-tick next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module i2cm_step
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire item_t       item,
	input  wire logic [15:0] phase_delay,
	output result_t          result
);

	logic [2:0]  cmd_q;
	logic [1:0]  phase_q;
	logic [3:0]  group_q;
	logic [15:0] dly_q;
	logic [7:0]  shift_q;
	logic [7:0]  tx_q;
	line_t       line_q;
	logic        ack_q;

	logic [2:0]  cmd_d;
	logic [1:0]  phase_d;
	logic [3:0]  group_d;
	logic [15:0] dly_d;
	logic [7:0]  shift_d;
	logic [7:0]  tx_d;
	line_t       line_d;
	logic        ack_d;
	logic        done;
	logic        rej;
	logic        is_cmd;
	logic        is_read;
	logic [2:0]  phase_inc;
	logic [2:0]  phase_cnt;
	logic [3:0]  group_inc;
	logic [3:0]  group_cnt;
	logic [15:0] dly_load;

	// Line pattern held during phase p of group g of command cmd.
	function automatic line_t phase_lines(logic [2:0] cmd, logic [1:0] p, logic [3:0] g,
		logic tx_msb, line_t cur);
		line_t l;
		logic  ack_bit;
		begin
			l       = cur;
			ack_bit = (cmd == MODE_READ_NACK);
			unique case (cmd)
				MODE_START: begin
					if (p == 2'd0) l = '{drv: 1'b1, sda: 1'b1, scl: 1'b0};
					else if (p == 2'd1) l = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
					else l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
				end
				MODE_STOP: begin
					if (p == 2'd0) l = '{drv: 1'b1, sda: 1'b0, scl: 1'b0};
					else if (p == 2'd1) l = '{drv: 1'b1, sda: 1'b0, scl: 1'b1};
					else l = '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
				end
				MODE_WRITE: begin
					if (p == 2'd0) l.scl = 1'b0;
					else if (g < 4'd8) l = '{drv: 1'b1, sda: tx_msb, scl: (p == 2'd2)};
					else l = '{drv: 1'b0, sda: 1'b1, scl: (p == 2'd2)};
				end
				MODE_READ_ACK, MODE_READ_NACK: begin
					if (g == 4'd0) begin
						if (p == 2'd0) l.scl = 1'b0;
						else l = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
					end else if (g <= 4'd8) begin
						if (p == 2'd0) l = '{drv: 1'b0, sda: 1'b1, scl: (g != 4'd1)};
						else l = '{drv: 1'b0, sda: 1'b1, scl: (p == 2'd2)};
					end else begin
						if (p == 2'd0) l = '{drv: 1'b0, sda: 1'b1, scl: 1'b0};
						else l = '{drv: 1'b1, sda: ack_bit, scl: (p == 2'd2)};
					end
				end
				default: l = cur;
			endcase
			return l;
		end
	endfunction

	always_comb begin
		cmd_d   = cmd_q;
		phase_d = phase_q;
		group_d = group_q;
		dly_d   = dly_q;
		shift_d = shift_q;
		tx_d    = tx_q;
		line_d  = line_q;
		ack_d   = ack_q;
		done    = 1'b0;
		rej     = 1'b0;

		is_cmd    = (item.mode >= MODE_START) && (item.mode <= MODE_READ_NACK);
		is_read   = (cmd_q == MODE_READ_ACK) || (cmd_q == MODE_READ_NACK);
		dly_load  = (phase_delay == 16'd0) ? 16'd0 : phase_delay - 16'd1;
		phase_inc = {1'b0, phase_q} + 3'd1;
		phase_cnt = (is_read && group_q == 4'd0) ? 3'd2 : 3'd3;
		group_inc = group_q + 4'd1;
		if (cmd_q == MODE_WRITE) group_cnt = 4'd9;
		else if (is_read) group_cnt = 4'd10;
		else group_cnt = 4'd1;

		if (cmd_q == MODE_NONE) begin
			if (is_cmd) begin
				cmd_d   = item.mode;
				phase_d = 2'd0;
				group_d = 4'd0;
				dly_d   = dly_load;
				if (item.mode == MODE_WRITE) begin
					tx_d  = item.tx_byte;
					ack_d = 1'b0;
				end
				if (item.mode == MODE_READ_ACK || item.mode == MODE_READ_NACK) begin
					shift_d = 8'd0;
				end
				line_d = phase_lines(item.mode, 2'd0, 4'd0, item.tx_byte[BYTE_MSB], line_q);
			end
		end else begin
			rej = is_cmd;
			if (dly_q != 16'd0) begin
				dly_d = dly_q - 16'd1;
			end else begin
				// The high-clock phase of a write bit or a read data bit ends with a shift or an acknowledge sample.
				if (phase_q == 2'd2) begin
					if (cmd_q == MODE_WRITE) begin
						if (group_q < 4'd8) tx_d = {tx_q[6:0], 1'b0};
						else ack_d = ~item.sda_sample;
					end else if (is_read && group_q >= 4'd1 && group_q <= 4'd8) begin
						shift_d = {shift_q[6:0], item.sda_sample};
					end
				end
				phase_d = phase_inc[1:0];
				if (phase_inc >= phase_cnt) begin
					phase_d = 2'd0;
					group_d = group_inc;
					if (group_inc >= group_cnt) begin
						line_d.scl = 1'b0;
						line_d.drv = 1'b1;
						cmd_d      = MODE_NONE;
						group_d    = 4'd0;
						done       = 1'b1;
					end
				end
				if (cmd_d != MODE_NONE) begin
					dly_d  = dly_load;
					line_d = phase_lines(cmd_d, phase_d, group_d, tx_d[BYTE_MSB], line_q);
				end
			end
		end

		result.scl_level    = line_d.scl;
		result.sda_level    = line_d.sda;
		result.sda_drive    = line_d.drv;
		result.busy_res     = (cmd_d != MODE_NONE);
		result.done_res     = done;
		result.rx_byte      = shift_d;
		result.slave_ack    = ack_d;
		result.cmd_rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= MODE_NONE;
			phase_q <= 2'd0;
			group_q <= 4'd0;
			dly_q   <= 16'd0;
			shift_q <= 8'd0;
			tx_q    <= 8'd0;
			line_q  <= '{drv: 1'b1, sda: 1'b1, scl: 1'b1};
			ack_q   <= 1'b0;
		end else if (go) begin
			cmd_q   <= cmd_d;
			phase_q <= phase_d;
			group_q <= group_d;
			dly_q   <= dly_d;
			shift_q <= shift_d;
			tx_q    <= tx_d;
			line_q  <= line_d;
			ack_q   <= ack_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/i2c_master_byte_engine_top.sv -----
// Top level of the I2C master byte engine: input register, bit engine, result register.
`timescale 1ns / 1ps
`default_nettype none
// Each input transfer is one tick of the I2C bit engine and produces exactly one result
// transfer carrying the SCL/SDA drive pattern and status after that tick. The block
// takes one tick per clock cycle while results are taken; a tick passes through an input
// register and then the result register; a tick waits in the input register while the
// result register is full and not taken. The rate is set by the next-state logic of the
// bit engine, which updates its line and counter registers once per tick.
// phase_delay (reset 13) is written through cfg_we/cfg_wdata; the user must write it
// only while the engine is idle, and the block itself does not enforce this.
module i2c_master_byte_engine_top
	import i2cm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	i2cm_in_if.sink          in_ch,
	i2cm_out_if.source       out_ch
);

	logic [15:0] phase_delay_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	result_t     res_q;
	result_t     step_res;
	logic        out_free;
	logic        step_go;

	assign out_free     = !out_valid_q || out_ch.ready;
	assign step_go      = valid_s1 && out_free;
	assign in_ch.ready  = !valid_s1 || step_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= PHASE_DELAY_RESET;
		end else if (cfg_we) begin
			phase_delay_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= '{mode: in_ch.mode, tx_byte: in_ch.tx_byte,
				sda_sample: in_ch.sda_sample};
		end
	end

	i2cm_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (step_go),
		.item        (item_s1),
		.phase_delay (phase_delay_q),
		.result      (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step_go;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go) begin
			res_q <= step_res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.scl_level    = res_q.scl_level;
	assign out_ch.sda_level    = res_q.sda_level;
	assign out_ch.sda_drive    = res_q.sda_drive;
	assign out_ch.busy_res     = res_q.busy_res;
	assign out_ch.done_res     = res_q.done_res;
	assign out_ch.rx_byte      = res_q.rx_byte;
	assign out_ch.slave_ack    = res_q.slave_ack;
	assign out_ch.cmd_rejected = res_q.cmd_rejected;

`ifndef SYNTHESIS
	// A tick waiting for a full result register must stay in the input register.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a tick while the result register was full");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		step_go |=> out_valid_q)
		else $error("engine step produced no result transfer");

	// A finishing command leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done reported while still busy");
`endif

endmodule
`default_nettype wire
